// ----- sv/mse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants, command and status codes, and word types of the
// multiple stack engine.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int NUM_STACKS  = 16;
  localparam int STACK_DEPTH = 64;

  localparam int IDX_W   = 4;
  localparam int PTR_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = IDX_W + PTR_W;
  localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
  localparam int SIU_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  localparam logic [SIU_W-1:0] SIU_RESET = SIU_W'(16);

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  stack_index;
    logic [IDX_W-1:0]  dest_index;
    logic [BYTE_W-1:0] push_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] popped_byte;
    logic [STAT_W-1:0] status;
  } out_word_t;

endpackage

// ----- sv/mse_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/multi_stack_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stack_engine
// Bank of byte stacks with push, pop and move commands, one status per word.
// ----------------------------------------------------------------------------
// One command word is taken in every cycle; busy is always low. Its result
// word shows on out_word with out_valid high for one cycle, in the cycle
// after acceptance, as the stack memory has a registered read port.
// Top counts live in flip-flops and are cleared by reset, so no clearing pass
// is needed. The receiver cannot stall: it must take every result word as it
// appears. cfg_wdata sets the number of enabled stacks (reset 16); the user
// must write it only while no command is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module multi_stack_engine
  import mse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_valid,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [SIU_W-1:0] cfg_wdata
);

  logic [SIU_W-1:0]  siu_r;
  logic [CNT_W-1:0]  top_r [NUM_STACKS];
  logic [CNT_W-1:0]  top_nxt [NUM_STACKS];

  logic              acc;
  logic [IDX_W-1:0]  src;
  logic [IDX_W-1:0]  dst;
  logic              src_ok;
  logic              dst_ok;
  logic [CNT_W-1:0]  tc_src;
  logic [CNT_W-1:0]  tc_dst;
  logic [CNT_W-1:0]  tc_dec;
  logic              src_empty;
  logic              src_full;
  logic              dst_full;

  logic [STAT_W-1:0] status_nxt;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic              wen_nxt;
  logic [ADDR_W-1:0] waddr_nxt;
  logic              pop_ok_nxt;
  logic              inc_src;
  logic              dec_src;
  logic              inc_dst;

  logic              valid_r;
  logic [STAT_W-1:0] status_r;
  logic              pop_ok_r;
  logic              wen_r;
  logic [ADDR_W-1:0] waddr_r;
  logic              is_push_r;
  logic [BYTE_W-1:0] byte_r;
  logic              fwd_r;
  logic              fwd_nxt;
  logic [BYTE_W-1:0] fwd_data_r;

  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] rd_eff;
  logic [BYTE_W-1:0] wdata;

  assign busy = 1'b0;
  assign acc  = start & ~busy;
  assign src  = in_word.stack_index;
  assign dst  = in_word.dest_index;

  assign src_ok = (SIU_W'(src) < siu_r) && (SIU_W'(src) < SIU_W'(NUM_STACKS));
  assign dst_ok = (SIU_W'(dst) < siu_r) && (SIU_W'(dst) < SIU_W'(NUM_STACKS));

  assign tc_src    = top_r[src];
  assign tc_dst    = top_r[dst];
  assign tc_dec    = tc_src - CNT_W'(1);
  assign src_empty = (tc_src == '0);
  assign src_full  = (tc_src >= CNT_W'(STACK_DEPTH));
  assign dst_full  = (tc_dst >= CNT_W'(STACK_DEPTH));

  // command decode
  always_comb begin
    status_nxt = ST_OK;
    re         = 1'b0;
    raddr      = {src, tc_dec[PTR_W-1:0]};
    wen_nxt    = 1'b0;
    waddr_nxt  = {src, tc_src[PTR_W-1:0]};
    pop_ok_nxt = 1'b0;
    inc_src    = 1'b0;
    dec_src    = 1'b0;
    inc_dst    = 1'b0;
    case (in_word.op)
      OP_PUSH: begin
        if (!src_ok) begin
          status_nxt = ST_BADIDX;
        end else if (src_full) begin
          status_nxt = ST_FULL;
        end else begin
          wen_nxt = 1'b1;
          inc_src = 1'b1;
        end
      end
      OP_POP: begin
        if (!src_ok) begin
          status_nxt = ST_BADIDX;
        end else if (src_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          re         = 1'b1;
          pop_ok_nxt = 1'b1;
          dec_src    = 1'b1;
        end
      end
      OP_MOVE: begin
        if (!src_ok || !dst_ok) begin
          status_nxt = ST_BADIDX;
        end else if (src_empty) begin
          status_nxt = ST_EMPTY;
        end else if (src == dst) begin
          status_nxt = ST_OK;
        end else if (dst_full) begin
          status_nxt = ST_FULL;
        end else begin
          re        = 1'b1;
          wen_nxt   = 1'b1;
          waddr_nxt = {dst, tc_dst[PTR_W-1:0]};
          dec_src   = 1'b1;
          inc_dst   = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_BADIDX;
      end
    endcase
  end

  // top count update
  always_comb begin
    for (int i = 0; i < NUM_STACKS; i++) begin
      top_nxt[i] = top_r[i];
    end
    if (acc) begin
      if (inc_src) begin
        top_nxt[src] = tc_src + CNT_W'(1);
      end
      if (dec_src) begin
        top_nxt[src] = tc_dec;
      end
      if (inc_dst) begin
        top_nxt[dst] = tc_dst + CNT_W'(1);
      end
    end
  end

  // read of an entry written in the same cycle is bypassed
  assign rd_eff  = fwd_r ? fwd_data_r : ram_rdata;
  assign wdata   = is_push_r ? byte_r : rd_eff;
  assign fwd_nxt = acc & re & wen_r & (waddr_r == raddr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r   <= SIU_RESET;
      valid_r <= 1'b0;
      wen_r   <= 1'b0;
      fwd_r   <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        siu_r <= cfg_wdata;
      end
      valid_r <= acc;
      wen_r   <= acc & wen_nxt;
      fwd_r   <= fwd_nxt;
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i] <= top_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    pop_ok_r   <= pop_ok_nxt;
    waddr_r    <= waddr_nxt;
    is_push_r  <= (in_word.op == OP_PUSH);
    byte_r     <= in_word.push_byte;
    fwd_data_r <= wdata;
  end

  mse_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wen_r),
    .waddr (waddr_r),
    .wdata (wdata),
    .re    (acc & re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign out_valid            = valid_r;
  assign out_word.status      = status_r;
  assign out_word.popped_byte = pop_ok_r ? rd_eff : '0;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted word gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> !out_valid)
    else $error("result without accepted word");

  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    wen_r |-> (out_valid && out_word.status == ST_OK))
    else $error("store written by a failed or absent command");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tc_src <= CNT_W'(STACK_DEPTH))
    else $error("top count beyond depth");

  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && pop_ok_nxt) |=> (out_valid && out_word.status == ST_OK && !wen_r))
    else $error("pop result inconsistent");

endmodule

// ----- dv/multi_stack_engine_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stack_engine_test
// Self-checking bench for the multiple stack engine. A queue-fed driver sends
// push, pop, move and unknown commands with random idle gaps. A monitor keeps
// its own copy of the stacks, predicts every result word and compares it field
// by field. The run steps through several enabled-stack counts, from none to
// above the bank size, with short fill and drain phases that reach full and
// empty stacks.
// ----------------------------------------------------------------------------
module multi_stack_engine_test;
  import mse_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    in_word_t    cmd;
    int unsigned idle;
  } queued_cmd_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_word_t         in_word   = '0;
  logic             out_valid;
  out_word_t        out_word;
  logic             cfg_we    = 1'b0;
  logic [SIU_W-1:0] cfg_wdata = '0;

  multi_stack_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // stack bank as the block should hold it
  logic [BYTE_W-1:0] stack_mem [NUM_STACKS][STACK_DEPTH];
  int               top_of    [NUM_STACKS];
  logic [SIU_W-1:0] stacks_on;

  out_word_t   results_due[$];
  queued_cmd_t cmd_q[$];
  queued_cmd_t head;
  out_word_t   due;

  int unsigned words_sent  = 0;
  int unsigned words_taken = 0;
  int unsigned idle_left   = 0;
  bit          gap_loaded  = 1'b0;
  bit          gaps_on     = 1'b1;
  int          errors      = 0;
  int          settings_run = 1;
  int          status_seen [4] = '{0, 0, 0, 0};
  logic [SIU_W-1:0] stacks_cfg = SIU_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d words still due", results_due.size());
    $display("multi_stack_engine_test NOT OK");
    $finish;
  end

  function automatic bit slot_ok(logic [IDX_W-1:0] idx);
    return int'(idx) < int'(stacks_on) && int'(idx) < NUM_STACKS;
  endfunction

  function automatic out_word_t apply_command(in_word_t w);
    out_word_t        r;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] d;
    s = w.stack_index;
    d = w.dest_index;
    r = '0;
    r.status = ST_OK;
    case (w.op)
      OP_PUSH: begin
        if (!slot_ok(s)) begin
          r.status = ST_BADIDX;
        end else if (top_of[s] >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[s][top_of[s]] = w.push_byte;
          top_of[s]++;
        end
      end
      OP_POP: begin
        if (!slot_ok(s)) begin
          r.status = ST_BADIDX;
        end else if (top_of[s] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          top_of[s]--;
          r.popped_byte = stack_mem[s][top_of[s]];
        end
      end
      OP_MOVE: begin
        if (!slot_ok(s) || !slot_ok(d)) begin
          r.status = ST_BADIDX;
        end else if (top_of[s] == 0) begin
          r.status = ST_EMPTY;
        end else if (s == d) begin
          r.status = ST_OK;
        end else if (top_of[d] >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          top_of[s]--;
          stack_mem[d][top_of[d]] = stack_mem[s][top_of[s]];
          top_of[d]++;
        end
      end
      default: r.status = ST_BADIDX;
    endcase
    return r;
  endfunction

  // driver: one word offered at a time, idle gap drawn per word
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_loaded = 1'b0;
    end else if (!start || words_taken == words_sent) begin
      if (cmd_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        if (!gap_loaded) begin
          idle_left  = cmd_q[0].idle;
          gap_loaded = 1'b1;
        end
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else begin
          head = cmd_q.pop_front();
          in_word <= head.cmd;
          start   <= 1'b1;
          words_sent++;
          gap_loaded = 1'b0;
        end
      end
    end
  end

  // monitor: check result words, then predict for the word taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (top_of[i]) top_of[i] = 0;
      stacks_on = SIU_RESET;
    end else begin
      if (out_valid !== 1'b0) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%t unexpected result word, actual %h", $time, out_word);
        end else begin
          due = results_due.pop_front();
          status_seen[due.status]++;
          if (out_word.popped_byte !== due.popped_byte) begin
            errors++;
            $display("%t popped_byte mismatch, expected %h actual %h",
                     $time, due.popped_byte, out_word.popped_byte);
          end
          if (out_word.status !== due.status) begin
            errors++;
            $display("%t status mismatch, expected %0d actual %0d",
                     $time, due.status, out_word.status);
          end
        end
      end
      if (start && busy === 1'b0) begin
        results_due.insert(results_due.size(), apply_command(in_word));
        words_taken++;
      end
      if (cfg_we) begin
        stacks_on = cfg_wdata;
      end
    end
  end

  task automatic add_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] s, logic [IDX_W-1:0] d,
                         logic [BYTE_W-1:0] b);
    queued_cmd_t q;
    q.cmd.op          = op;
    q.cmd.stack_index = s;
    q.cmd.dest_index  = d;
    q.cmd.push_byte   = b;
    if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
    q.idle = gaps_on ? $urandom_range(0, 13) : 0;
    cmd_q.insert(cmd_q.size(), q);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    int eff;
    eff = (stacks_cfg > NUM_STACKS) ? NUM_STACKS : int'(stacks_cfg);
    if (eff == 0 || $urandom_range(0, 4) == 0) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom_range(0, eff - 1));
  endfunction

  task automatic add_random(int n, int w_push, int w_pop, int w_move);
    int               r;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] d;
    for (int k = 0; k < n; k++) begin
      r  = $urandom_range(0, 99);
      op = (r < w_push) ? OP_PUSH :
           (r < w_push + w_pop) ? OP_POP :
           (r < w_push + w_pop + w_move) ? OP_MOVE : OP_UNKNOWN;
      s  = pick_index();
      d  = ($urandom_range(0, 7) == 0) ? s : pick_index();
      add_cmd(op, s, d, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || words_taken != words_sent || results_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_stacks(logic [SIU_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    stacks_cfg = v;
    settings_run++;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // empty stacks, edge bytes, self moves, unknown command
    add_cmd(OP_POP, 4'd0, 4'd0, 8'h00);
    add_cmd(OP_MOVE, 4'd0, 4'd1, 8'h00);
    add_cmd(OP_MOVE, 4'd0, 4'd0, 8'h00);
    add_cmd(OP_PUSH, 4'd0, 4'd15, 8'h00);
    add_cmd(OP_PUSH, 4'd15, 4'd0, 8'hFF);
    add_cmd(OP_PUSH, 4'd15, 4'd0, 8'h5A);
    add_cmd(OP_POP, 4'd15, 4'd15, 8'hFF);
    add_cmd(OP_MOVE, 4'd15, 4'd0, 8'h00);
    add_cmd(OP_MOVE, 4'd0, 4'd0, 8'hFF);
    add_cmd(OP_POP, 4'd0, 4'd0, 8'h00);
    add_cmd(OP_POP, 4'd0, 4'd0, 8'h00);
    add_cmd(OP_UNKNOWN, 4'd15, 4'd15, 8'hFF);
    add_cmd(OP_PUSH, 4'd8, 4'd0, 8'h80);
    add_cmd(OP_MOVE, 4'd8, 4'd7, 8'h00);
    add_cmd(OP_POP, 4'd7, 4'd0, 8'h00);
    add_cmd(OP_PUSH, 4'd1, 4'd0, 8'h01);

    // indices beyond the enabled count
    set_stacks(5'd4);
    add_cmd(OP_PUSH, 4'd4, 4'd0, 8'h33);
    add_cmd(OP_POP, 4'd9, 4'd0, 8'h00);
    add_cmd(OP_MOVE, 4'd1, 4'd4, 8'h00);
    add_cmd(OP_MOVE, 4'd12, 4'd1, 8'h00);
    add_cmd(OP_POP, 4'd1, 4'd0, 8'h00);

    set_stacks(5'd31);
    add_random(350, 40, 30, 25);
    set_stacks(5'd2);
    add_random(350, 65, 10, 20);
    set_stacks(5'd1);
    add_random(150, 15, 65, 15);
    set_stacks(5'd0);
    add_random(50, 30, 30, 30);
    set_stacks(5'd16);
    add_random(300, 40, 30, 25);
    set_stacks(5'd5);
    add_random(300, 60, 20, 15);
    set_stacks(5'd17);
    add_random(250, 20, 60, 15);

    wait_idle();
    repeat (4) @(negedge clk);
    $display("covered %0d commands under %0d enabled-stack settings", words_taken,
             settings_run);
    $display("result mix: ok %0d, empty %0d, full %0d, bad index %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BADIDX]);
    if (errors == 0 && results_due.size() == 0) begin
      $display("multi_stack_engine_test OK");
    end else begin
      $display("multi_stack_engine_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mse_pkg.sv
sv/mse_ram.sv
sv/multi_stack_engine.sv
dv/multi_stack_engine_test.sv
